// ===== hdl/vit_pkg.sv =====
`timescale 1ns / 1ps

package vit_pkg;

  // Default table depth; the top level parameter takes it from here.
  localparam int unsigned TableEntriesDef = 1024;

  // Depth of the command queue between the front and the back.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  // Operation codes of the input item.
  localparam logic [2:0] OP_BIND    = 3'd0;
  localparam logic [2:0] OP_REBIND  = 3'd1;
  localparam logic [2:0] OP_ERASE   = 3'd2;
  localparam logic [2:0] OP_FIND    = 3'd3;
  localparam logic [2:0] OP_FIND_AT = 3'd4;

  // Status codes of the result item.
  localparam logic [2:0] ST_OK            = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND     = 3'd1;
  localparam logic [2:0] ST_ALREADY_BOUND = 3'd2;
  localparam logic [2:0] ST_ID_ZERO       = 3'd3;
  localparam logic [2:0] ST_BEYOND        = 3'd4;

  // Action decided by the front for the back.
  typedef enum logic [2:0] {
    ACT_BIND,
    ACT_REBIND,
    ACT_ERASE,
    ACT_FIND,
    ACT_FIND_AT,
    ACT_REJECT
  } act_e;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] object_id;
    logic [63:0] rec_page;
    logic [15:0] rec_slot;
    logic [15:0] rec_gen;
    logic [63:0] epoch;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] out_page;
    logic [15:0] out_slot;
    logic [15:0] out_gen;
    logic [63:0] out_epoch;
    logic        has_prior;
  } out_t;

  // One record location with the epoch of its version.
  typedef struct packed {
    logic [63:0] page;
    logic [15:0] slot;
    logic [15:0] gen;
    logic [63:0] epoch;
  } rec_t;

  // One table entry as it sits in the memory.
  typedef struct packed {
    logic bound;
    logic removed;
    logic prior_valid;
    rec_t cur;
    rec_t prior;
  } ent_t;

  // Classified command passed through the queue.
  typedef struct packed {
    act_e        act;
    logic [2:0]  rej_status;
    logic [31:0] object_id;
    rec_t        rec;
  } cmd_t;

endpackage

// ===== hdl/versioned_identity_table.sv =====
`timescale 1ns / 1ps
// An input transfer is written into the command queue; the back then reads its table entry
// into a register in the idle state and, once the output is free, writes the entry back and
// loads the result register in the execute state, so each command finishes before the next.
// Reset: asynchronous, active low. After reset the table flags are cleared by a sweep over
// all TABLE_ENTRIES entries, one entry per cycle, during which in_ready_o stays low.

module versioned_identity_table #(
  parameter int unsigned TABLE_ENTRIES = vit_pkg::TableEntriesDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  vit_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output vit_pkg::out_t out_data_o
);
  import vit_pkg::*;

  cmd_t push_cmd;
  cmd_t head_cmd;
  logic push;
  logic pop;
  logic q_full;
  logic q_valid;
  logic clr_busy;

  // Front: takes transfers and classifies them.
  vit_front #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .clr_busy_i (clr_busy),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  // Command queue between the two sides.
  vit_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .head_o  (head_cmd)
  );

  // Back: table access and result register.
  vit_back #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .head_i      (head_cmd),
    .pop_o       (pop),
    .clr_busy_o  (clr_busy),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // No command may wait in the queue while the table is being cleared.
  a_clear_queue_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> !q_valid)
    else $error("command queued during table clear");

  // The queue never takes a command when full.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !push)
    else $error("push into full queue");

  // Every executed command presents a result in the next cycle.
  a_pop_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> out_valid_o)
    else $error("executed command produced no result");

  // A pop only happens when a command is waiting.
  a_pop_needs_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_valid)
    else $error("pop from empty queue");

endmodule

// ===== hdl/vit_front.sv =====
`timescale 1ns / 1ps

module vit_front #(
  parameter int unsigned TABLE_ENTRIES = vit_pkg::TableEntriesDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  vit_pkg::in_t  in_data_i,
  input  logic          q_full_i,
  input  logic          clr_busy_i,
  output logic          push_o,
  output vit_pkg::cmd_t cmd_o
);
  import vit_pkg::*;

  localparam logic [32:0] EntriesL = 33'(TABLE_ENTRIES);

  logic in_range;
  logic id_zero;
  logic seen_q;

  // Items are taken whenever the queue has room, the table is not being cleared and reset is left.
  assign in_ready_o = !q_full_i && !clr_busy_i && seen_q;
  assign push_o     = in_valid_i && in_ready_o;

  // The front stays closed until the first clock edge out of reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
    end else begin
      seen_q <= 1'b1;
    end
  end

  assign in_range = {1'b0, in_data_i.object_id} < EntriesL;
  assign id_zero  = in_data_i.object_id == 32'd0;

  // Classify the item and settle every rejection that needs no table lookup.
  always_comb begin
    cmd_o.object_id  = in_data_i.object_id;
    cmd_o.rec.page   = in_data_i.rec_page;
    cmd_o.rec.slot   = in_data_i.rec_slot;
    cmd_o.rec.gen    = in_data_i.rec_gen;
    cmd_o.rec.epoch  = in_data_i.epoch;
    cmd_o.act        = ACT_REJECT;
    cmd_o.rej_status = ST_NOT_FOUND;
    unique case (in_data_i.op)
      OP_BIND: begin
        if (id_zero) begin
          cmd_o.rej_status = ST_ID_ZERO;
        end else if (!in_range) begin
          cmd_o.rej_status = ST_BEYOND;
        end else begin
          cmd_o.act = ACT_BIND;
        end
      end
      OP_REBIND: begin
        if (in_range) cmd_o.act = ACT_REBIND;
      end
      OP_ERASE: begin
        if (in_range) cmd_o.act = ACT_ERASE;
      end
      OP_FIND: begin
        if (in_range) cmd_o.act = ACT_FIND;
      end
      OP_FIND_AT: begin
        if (in_range) cmd_o.act = ACT_FIND_AT;
      end
      default: begin
        cmd_o.act = ACT_REJECT;
      end
    endcase
  end

endmodule

// ===== hdl/vit_queue.sv =====
`timescale 1ns / 1ps

module vit_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  vit_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output vit_pkg::cmd_t head_o
);
  import vit_pkg::*;

  localparam logic [QPtrW-1:0] LastPtr = QPtrW'(QueueDepth - 1);
  localparam logic [QCntW-1:0] FullCnt = QCntW'(QueueDepth);

  cmd_t             slot_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == FullCnt;
  assign valid_o = cnt_q != '0;
  assign head_o  = slot_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage holds payload only.
  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= cmd_i;
  end

endmodule

// ===== hdl/vit_back.sv =====
`timescale 1ns / 1ps

module vit_back #(
  parameter int unsigned TABLE_ENTRIES = vit_pkg::TableEntriesDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  vit_pkg::cmd_t head_i,
  output logic          pop_o,
  output logic          clr_busy_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output vit_pkg::out_t out_data_o
);
  import vit_pkg::*;

  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_ENTRIES - 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  ent_t            mem_q [TABLE_ENTRIES];
  ent_t            rd_q;
  ent_t            wr_word;
  logic            wr_en;
  logic            rd_en;
  logic [IdxW-1:0] idx;
  logic            state_q, state_d;
  logic            clr_busy_q;
  logic [IdxW-1:0] clr_idx_q;
  logic            exec_fire;
  logic            live;
  logic            cur_seen;
  logic            prior_seen;
  out_t            res;
  out_t            out_q;
  logic            out_valid_q;

  assign idx        = head_i.object_id[IdxW-1:0];
  assign clr_busy_o = clr_busy_q;

  // Read the entry in the idle state, then execute and write back in the execute state.
  assign rd_en     = (state_q == S_IDLE) && q_valid_i && (head_i.act != ACT_REJECT);
  assign exec_fire = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);
  assign pop_o     = exec_fire;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (q_valid_i && !clr_busy_q) state_d = S_EXEC;
      S_EXEC: if (exec_fire) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Entry update and result selection.
  assign live       = rd_q.bound && !rd_q.removed;
  assign cur_seen   = rd_q.cur.epoch <= head_i.rec.epoch;
  assign prior_seen = rd_q.prior_valid && (rd_q.prior.epoch <= head_i.rec.epoch);

  always_comb begin
    wr_word    = rd_q;
    wr_en      = 1'b0;
    res        = '0;
    res.status = ST_NOT_FOUND;
    unique case (head_i.act)
      ACT_BIND: begin
        if (rd_q.bound) begin
          res.status = ST_ALREADY_BOUND;
        end else begin
          wr_word.bound       = 1'b1;
          wr_word.removed     = 1'b0;
          wr_word.prior_valid = 1'b0;
          wr_word.cur         = head_i.rec;
          wr_en               = 1'b1;
          res.status          = ST_OK;
        end
      end
      ACT_REBIND, ACT_ERASE: begin
        if (live) begin
          wr_word.prior       = rd_q.cur;
          wr_word.prior_valid = 1'b1;
          wr_word.cur.epoch   = head_i.rec.epoch;
          if (head_i.act == ACT_REBIND) begin
            wr_word.cur.page = head_i.rec.page;
            wr_word.cur.slot = head_i.rec.slot;
            wr_word.cur.gen  = head_i.rec.gen;
          end else begin
            wr_word.cur.page = '0;
            wr_word.cur.slot = '0;
            wr_word.cur.gen  = '0;
            wr_word.removed  = 1'b1;
          end
          wr_en      = 1'b1;
          res.status = ST_OK;
        end
      end
      ACT_FIND: begin
        if (live) begin
          res.status    = ST_OK;
          res.out_page  = rd_q.cur.page;
          res.out_slot  = rd_q.cur.slot;
          res.out_gen   = rd_q.cur.gen;
          res.out_epoch = rd_q.cur.epoch;
          res.has_prior = rd_q.prior_valid;
        end
      end
      ACT_FIND_AT: begin
        if (rd_q.bound) begin
          if (cur_seen) begin
            if (!rd_q.removed) begin
              res.status    = ST_OK;
              res.out_page  = rd_q.cur.page;
              res.out_slot  = rd_q.cur.slot;
              res.out_gen   = rd_q.cur.gen;
              res.out_epoch = rd_q.cur.epoch;
              res.has_prior = rd_q.prior_valid;
            end
          end else if (prior_seen) begin
            res.status    = ST_OK;
            res.out_page  = rd_q.prior.page;
            res.out_slot  = rd_q.prior.slot;
            res.out_gen   = rd_q.prior.gen;
            res.out_epoch = rd_q.prior.epoch;
            res.has_prior = 1'b1;
          end
        end
      end
      default: begin
        res.status = head_i.rej_status;
      end
    endcase
  end

  // Control registers: sequencer, clearing sweep and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      clr_busy_q  <= 1'b1;
      clr_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (clr_busy_q) begin
        clr_idx_q <= clr_idx_q + 1'b1;
        if (clr_idx_q == LastIdx) clr_busy_q <= 1'b0;
      end
      if (exec_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (exec_fire) out_q <= res;
  end

  // Table memory: one write port shared by the clearing sweep, one registered read port.
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem_q[clr_idx_q] <= '0;
    end else if (exec_fire && wr_en) begin
      mem_q[idx] <= wr_word;
    end
    if (rd_en) rd_q <= mem_q[idx];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import vit_pkg::*;

  localparam int unsigned LastId     = TableEntriesDef - 1;
  localparam int unsigned RandomCmds = 1700;
  localparam int unsigned DrainAt    = 900;
  localparam int unsigned HoldAt     = 400;
  localparam int unsigned HoldLen    = 150;
  localparam int unsigned StallLimit = 5000;
  localparam int unsigned TailCycles = 20;
  localparam int unsigned ReportMax  = 10;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  versioned_identity_table dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  // Shadow copy of the identity table.
  logic bound_tbl    [TableEntriesDef];
  logic removed_tbl  [TableEntriesDef];
  logic prior_ok_tbl [TableEntriesDef];
  rec_t cur_tbl      [TableEntriesDef];
  rec_t prior_tbl    [TableEntriesDef];

  in_t  pending_cmds[$];
  out_t expected_replies[$];

  int unsigned total_cmds;
  int unsigned sent_cnt;
  int unsigned fail_cnt;
  int unsigned quiet_cycles;
  int unsigned hold_left;
  logic        hold_done;
  logic        in_accepted;

  always #5 clk = ~clk;

  // A lookup reply that serves one stored version.
  function automatic out_t serve_version(rec_t ver, logic prior_flag);
    out_t reply;
    reply.status    = ST_OK;
    reply.out_page  = ver.page;
    reply.out_slot  = ver.slot;
    reply.out_gen   = ver.gen;
    reply.out_epoch = ver.epoch;
    reply.has_prior = prior_flag;
    return reply;
  endfunction

  // Applies one command to the shadow table and returns the reply it produces.
  function automatic out_t apply_table_op(in_t cmd);
    out_t        reply;
    logic        in_range;
    int unsigned idx;
    logic        live;
    reply        = '0;
    reply.status = ST_NOT_FOUND;
    in_range     = cmd.object_id < TableEntriesDef;
    idx          = in_range ? cmd.object_id : 0;
    live         = in_range && bound_tbl[idx] && !removed_tbl[idx];
    case (cmd.op)
      OP_BIND: begin
        if (cmd.object_id == 0) begin
          reply.status = ST_ID_ZERO;
        end else if (!in_range) begin
          reply.status = ST_BEYOND;
        end else if (bound_tbl[idx]) begin
          reply.status = ST_ALREADY_BOUND;
        end else begin
          bound_tbl[idx]     = 1'b1;
          removed_tbl[idx]   = 1'b0;
          prior_ok_tbl[idx]  = 1'b0;
          cur_tbl[idx].page  = cmd.rec_page;
          cur_tbl[idx].slot  = cmd.rec_slot;
          cur_tbl[idx].gen   = cmd.rec_gen;
          cur_tbl[idx].epoch = cmd.epoch;
          reply.status       = ST_OK;
        end
      end
      OP_REBIND, OP_ERASE: begin
        if (live) begin
          prior_tbl[idx]    = cur_tbl[idx];
          prior_ok_tbl[idx] = 1'b1;
          if (cmd.op == OP_REBIND) begin
            cur_tbl[idx].page = cmd.rec_page;
            cur_tbl[idx].slot = cmd.rec_slot;
            cur_tbl[idx].gen  = cmd.rec_gen;
          end else begin
            cur_tbl[idx].page = '0;
            cur_tbl[idx].slot = '0;
            cur_tbl[idx].gen  = '0;
            removed_tbl[idx]  = 1'b1;
          end
          cur_tbl[idx].epoch = cmd.epoch;
          reply.status       = ST_OK;
        end
      end
      OP_FIND: begin
        if (live) reply = serve_version(cur_tbl[idx], prior_ok_tbl[idx]);
      end
      OP_FIND_AT: begin
        // The current version wins when it is not newer than the snapshot.
        if (in_range && bound_tbl[idx]) begin
          if (cur_tbl[idx].epoch <= cmd.epoch) begin
            if (!removed_tbl[idx]) reply = serve_version(cur_tbl[idx], prior_ok_tbl[idx]);
          end else if (prior_ok_tbl[idx] && prior_tbl[idx].epoch <= cmd.epoch) begin
            reply = serve_version(prior_tbl[idx], 1'b1);
          end
        end
      end
      default: ;
    endcase
    return reply;
  endfunction

  task automatic queue_cmd(logic [2:0] op, logic [31:0] id, logic [63:0] page,
                           logic [15:0] slot, logic [15:0] gen, logic [63:0] ep);
    in_t cmd;
    cmd.op        = op;
    cmd.object_id = id;
    cmd.rec_page  = page;
    cmd.rec_slot  = slot;
    cmd.rec_gen   = gen;
    cmd.epoch     = ep;
    pending_cmds.push_back(cmd);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Idle rates per phase: sender light and receiver heavy, then swapped, then none.
  function automatic int unsigned send_idle_pct();
    if (sent_cnt < total_cmds / 3) return 26;
    if (sent_cnt < 2 * total_cmds / 3) return 71;
    return 0;
  endfunction

  function automatic int unsigned recv_idle_pct();
    if (sent_cnt < total_cmds / 3) return 71;
    if (sent_cnt < 2 * total_cmds / 3) return 26;
    return 0;
  endfunction

  // Stimulus, reset and end of run.
  initial begin : stimulus
    int unsigned fresh_id;
    int unsigned id;
    int unsigned steps;
    int unsigned pick;
    int unsigned span;
    logic [63:0] base_ep;
    logic [63:0] now_ep;
    logic [63:0] snap;
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_ready   = 1'b0;
    sent_cnt    = 0;
    fail_cnt    = 0;
    hold_left   = 0;
    hold_done   = 1'b0;
    in_accepted = 1'b0;
    for (int i = 0; i < TableEntriesDef; i++) begin
      bound_tbl[i]    = 1'b0;
      removed_tbl[i]  = 1'b0;
      prior_ok_tbl[i] = 1'b0;
      cur_tbl[i]      = '0;
      prior_tbl[i]    = '0;
    end

    // Directed part: rejected binds, field extremes and the snapshot corner cases.
    queue_cmd(OP_BIND, 0, rand64(), 16'h1, 16'h2, 64'd3);
    queue_cmd(OP_BIND, TableEntriesDef, rand64(), 16'h1, 16'h2, 64'd3);
    queue_cmd(OP_BIND, '1, '1, '1, '1, '1);
    queue_cmd(OP_BIND, LastId, '1, '1, '1, '1);
    queue_cmd(OP_BIND, 1, '0, '0, '0, '0);
    queue_cmd(OP_BIND, 1, rand64(), 16'h5, 16'h6, 64'd1);
    queue_cmd(OP_FIND, LastId, '0, '0, '0, '0);
    queue_cmd(OP_FIND_AT, LastId, '0, '0, '0, '1);
    queue_cmd(OP_FIND_AT, LastId, '0, '0, '0, 64'hFFFF_FFFF_FFFF_FFFE);
    queue_cmd(OP_REBIND, LastId, rand64(), 16'hA5A5, 16'h5A5A, 64'd5);
    queue_cmd(OP_FIND_AT, LastId, '0, '0, '0, 64'd4);
    queue_cmd(OP_FIND, LastId, '0, '0, '0, '0);
    queue_cmd(OP_REBIND, 1, 64'h0123_4567_89AB_CDEF, 16'h00FF, 16'hFF00, 64'd10);
    queue_cmd(OP_FIND_AT, 1, '0, '0, '0, 64'd3);
    queue_cmd(OP_ERASE, 1, rand64(), '1, '1, 64'd20);
    queue_cmd(OP_FIND, 1, '0, '0, '0, '0);
    queue_cmd(OP_FIND_AT, 1, '0, '0, '0, 64'd25);
    queue_cmd(OP_FIND_AT, 1, '0, '0, '0, 64'd15);
    queue_cmd(OP_REBIND, 1, rand64(), 16'h7, 16'h8, 64'd30);
    queue_cmd(OP_ERASE, 1, '0, '0, '0, 64'd31);
    queue_cmd(OP_BIND, 1, rand64(), 16'h9, 16'hA, 64'd32);
    queue_cmd(OP_REBIND, 0, rand64(), 16'h1, 16'h1, 64'd1);
    queue_cmd(OP_FIND, 2000, '0, '0, '0, '0);
    queue_cmd(OP_FIND_AT, 7, '0, '0, '0, '1);
    for (int op = 5; op < 8; op++) queue_cmd(3'(op), LastId, rand64(), '1, '1, '1);

    // Random part: mostly bind-then-use sessions on fresh ids, the rest noise.
    fresh_id = 2;
    while (pending_cmds.size() < RandomCmds + 27) begin
      if ($urandom_range(99) < 80) begin
        if (fresh_id < LastId) begin
          id = fresh_id;
          fresh_id++;
        end else begin
          id = $urandom_range(1, LastId);
        end
        base_ep = rand64() >> $urandom_range(0, 63);
        now_ep  = base_ep;
        queue_cmd(OP_BIND, id, rand64(), 16'($urandom), 16'($urandom), now_ep);
        steps = $urandom_range(2, 8);
        repeat (steps) begin
          pick = $urandom_range(99);
          if (pick < 30) begin
            now_ep += 64'($urandom_range(0, 40));
            queue_cmd(OP_REBIND, id, rand64(), 16'($urandom), 16'($urandom), now_ep);
          end else if (pick < 40) begin
            now_ep += 64'($urandom_range(0, 40));
            queue_cmd(OP_ERASE, id, rand64(), 16'($urandom), 16'($urandom), now_ep);
          end else if (pick < 55) begin
            queue_cmd(OP_FIND, id, rand64(), 16'($urandom), 16'($urandom), rand64());
          end else if (pick < 92) begin
            // Snapshots land around every version the session wrote.
            span = 32'(now_ep - base_ep);
            snap = base_ep + 64'($urandom_range(0, span + 4)) - 64'd2;
            queue_cmd(OP_FIND_AT, id, rand64(), 16'($urandom), 16'($urandom), snap);
          end else begin
            queue_cmd(OP_BIND, id, rand64(), 16'($urandom), 16'($urandom), rand64());
          end
        end
      end else begin
        case ($urandom_range(4))
          0: id = 0;
          1: id = $urandom;
          2: id = TableEntriesDef + $urandom_range(0, 3);
          3: id = '1;
          default: id = $urandom_range(1, fresh_id);
        endcase
        queue_cmd(3'($urandom_range(0, 7)), id, rand64(), 16'($urandom), 16'($urandom),
                  rand64());
      end
    end
    total_cmds = pending_cmds.size();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (pending_cmds.size() != 0 || in_valid || expected_replies.size() != 0) begin
      @(posedge clk);
    end
    repeat (TailCycles) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Command driver: offers the next command once the previous transfer is done.
  always @(negedge clk) begin : cmd_driver
    in_t next_cmd;
    if (rst_n && (!in_valid || in_accepted)) begin
      if (pending_cmds.size() != 0 &&
          !(sent_cnt == DrainAt && expected_replies.size() != 0) &&
          $urandom_range(99) >= send_idle_pct()) begin
        next_cmd = pending_cmds.pop_front();
        in_data  <= next_cmd;
        in_valid <= 1'b1;
        sent_cnt <= sent_cnt + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Reply sink: random back-pressure plus one long hold-off to fill the block.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && sent_cnt >= HoldAt) begin
      out_ready <= 1'b0;
      hold_left <= HoldLen;
      hold_done <= 1'b1;
    end else begin
      out_ready <= $urandom_range(99) >= recv_idle_pct();
    end
  end

  // Scoreboard: predict on each command transfer, check each reply transfer.
  always @(posedge clk) begin : scoreboard
    out_t want;
    if (rst_n) begin
      in_accepted <= in_valid && in_ready;
      if (in_valid && in_ready) expected_replies.push_back(apply_table_op(in_data));
      if (out_valid && out_ready) begin
        if (expected_replies.size() == 0) begin
          if (fail_cnt < ReportMax) begin
            $display("%0t: reply with nothing expected: status %0d page %h", $realtime,
                     out_data.status, out_data.out_page);
          end
          fail_cnt++;
        end else begin
          want = expected_replies.pop_front();
          if (out_data.status !== want.status || out_data.out_page !== want.out_page ||
              out_data.out_slot !== want.out_slot || out_data.out_gen !== want.out_gen ||
              out_data.out_epoch !== want.out_epoch ||
              out_data.has_prior !== want.has_prior) begin
            if (fail_cnt < ReportMax) begin
              $display("%0t: reply mismatch", $realtime);
              $display("  expected status %0d page %h slot %h gen %h epoch %h prior %b",
                       want.status, want.out_page, want.out_slot, want.out_gen,
                       want.out_epoch, want.has_prior);
              $display("  actual   status %0d page %h slot %h gen %h epoch %h prior %b",
                       out_data.status, out_data.out_page, out_data.out_slot,
                       out_data.out_gen, out_data.out_epoch, out_data.has_prior);
            end
            fail_cnt++;
          end
        end
      end
    end
  end

  // Watchdog: too long without any transfer ends the run.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial quiet_cycles = 0;

endmodule

// ===== files.f =====
hdl/vit_pkg.sv
hdl/vit_front.sv
hdl/vit_queue.sv
hdl/vit_back.sv
hdl/versioned_identity_table.sv
verif/testbench.sv
